### sv/rfbc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the rectangle fill/border/copy blitter.
// No dependencies; imported by rfbc_walker and the top level.
package rfbc_pkg;

    localparam int unsigned SCREEN_WIDTH  = 1024;
    localparam int unsigned SCREEN_HEIGHT = 768;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned ADDR_W  = 17;
    localparam int unsigned COLOR_W = 32;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_DATA_W   = 8;
    localparam int unsigned M_DATA_W   = 104;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_X     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_Y     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_W     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_H     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y     = 4'd7;

    typedef enum logic [1:0] {
        MODE_FILL   = 2'd0,
        MODE_BORDER = 2'd1,
        MODE_COPY   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                mode;
        logic [COORD_W-1:0]   rect_x;
        logic [COORD_W-1:0]   rect_y;
        logic [COORD_W-1:0]   rect_w;
        logic [COORD_W-1:0]   rect_h;
        logic [COLOR_W-1:0]   fill_color;
        logic [COORD_W-1:0]   dest_x;
        logic [COORD_W-1:0]   dest_y;
    } t_cfg;

    typedef struct packed {
        logic                 active;
        logic [ADDR_W-1:0]    write_x;
        logic [ADDR_W-1:0]    write_y;
        logic                 write_en;
        logic                 is_copy;
        logic [ADDR_W-1:0]    read_x;
        logic [ADDR_W-1:0]    read_y;
        logic                 read_en;
        logic [COLOR_W-1:0]   pixel_color;
        logic                 last;
    } t_pix_op;

endpackage

### sv/rfbc_walker.sv
`timescale 1ns / 1ps
// Walk counters and pixel-operation generation for one step item.
// Depends on rfbc_pkg.
module rfbc_walker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rfbc_pkg::t_cfg   i_cfg,
    input  logic             i_restart,
    input  logic             i_accept,
    input  logic             i_step,
    output rfbc_pkg::t_pix_op o_op
);
    import rfbc_pkg::*;

    logic [COORD_W-1:0] r_outer, n_outer;
    logic [COORD_W-1:0] r_inner, n_inner;
    logic               r_rsp, n_rsp;
    logic               r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer <= '0;
            r_inner <= '0;
            r_rsp   <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_restart) begin
            r_outer <= '0;
            r_inner <= '0;
            r_rsp   <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_outer <= n_outer;
            r_inner <= n_inner;
            r_rsp   <= n_rsp;
            r_done  <= n_done;
        end
    end

    always_comb begin
        logic [COORD_W-1:0] xo;
        logic [COORD_W-1:0] yo;
        logic               issue;
        logic               is_last;
        logic               next_row;
        logic [ADDR_W-1:0]  wx;
        logic [ADDR_W-1:0]  wy;
        logic [ADDR_W-1:0]  rx;
        logic [ADDR_W-1:0]  ry;
        logic [ADDR_W-1:0]  inner_inc;

        n_outer   = r_outer;
        n_inner   = r_inner;
        n_rsp     = r_rsp;
        n_done    = r_done;
        xo        = '0;
        yo        = '0;
        issue     = 1'b0;
        is_last   = 1'b0;
        next_row  = 1'b0;
        inner_inc = {1'b0, r_inner} + ADDR_W'(1);
        o_op      = '0;

        if (!i_step) begin
            n_outer = '0;
            n_inner = '0;
            n_rsp   = 1'b0;
            n_done  = 1'b0;
        end else if (r_done) begin
            // walk finished: idle until restarted
        end else if (i_cfg.mode == MODE_NONE || i_cfg.rect_w == '0 || i_cfg.rect_h == '0) begin
            n_done = 1'b1;
        end else if (i_cfg.mode == MODE_BORDER) begin
            if (r_outer >= i_cfg.rect_h || r_inner >= i_cfg.rect_w) begin
                n_done = 1'b1;
            end else begin
                issue = 1'b1;
                yo    = r_outer;
                if (r_outer == '0 || r_outer == i_cfg.rect_h - COORD_W'(1)) begin
                    xo = r_inner;
                    if (inner_inc < {1'b0, i_cfg.rect_w}) begin
                        n_inner = inner_inc[COORD_W-1:0];
                    end else begin
                        next_row = 1'b1;
                    end
                    is_last = (r_outer == i_cfg.rect_h - COORD_W'(1)) &&
                              (r_inner == i_cfg.rect_w - COORD_W'(1));
                end else if (!r_rsp) begin
                    xo = '0;
                    if (i_cfg.rect_w > COORD_W'(1)) begin
                        n_rsp = 1'b1;
                    end else begin
                        next_row = 1'b1;
                    end
                end else begin
                    xo       = i_cfg.rect_w - COORD_W'(1);
                    n_rsp    = 1'b0;
                    next_row = 1'b1;
                end
                if (next_row) begin
                    n_inner = '0;
                    n_outer = r_outer + COORD_W'(1);
                end
            end
        end else begin
            // fill and copy: columns outer, rows inner
            if (r_outer >= i_cfg.rect_w || r_inner >= i_cfg.rect_h) begin
                n_done = 1'b1;
            end else begin
                issue   = 1'b1;
                xo      = r_outer;
                yo      = r_inner;
                is_last = (r_outer == i_cfg.rect_w - COORD_W'(1)) &&
                          (r_inner == i_cfg.rect_h - COORD_W'(1));
                if (inner_inc < {1'b0, i_cfg.rect_h}) begin
                    n_inner = inner_inc[COORD_W-1:0];
                end else begin
                    n_inner = '0;
                    n_outer = r_outer + COORD_W'(1);
                end
            end
        end

        if (is_last) begin
            n_done = 1'b1;
        end

        rx = {1'b0, i_cfg.rect_x} + {1'b0, xo};
        ry = {1'b0, i_cfg.rect_y} + {1'b0, yo};
        if (i_cfg.mode == MODE_COPY) begin
            wx = {1'b0, i_cfg.dest_x} + {1'b0, xo};
            wy = {1'b0, i_cfg.dest_y} + {1'b0, yo};
        end else begin
            wx = rx;
            wy = ry;
        end

        if (issue) begin
            o_op.active   = 1'b1;
            o_op.write_x  = wx;
            o_op.write_y  = wy;
            o_op.write_en = (wx < ADDR_W'(SCREEN_WIDTH)) && (wy < ADDR_W'(SCREEN_HEIGHT));
            o_op.last     = is_last;
            if (i_cfg.mode == MODE_COPY) begin
                o_op.is_copy = 1'b1;
                o_op.read_x  = rx;
                o_op.read_y  = ry;
                o_op.read_en = (rx < ADDR_W'(SCREEN_WIDTH)) && (ry < ADDR_W'(SCREEN_HEIGHT));
            end else begin
                o_op.pixel_color = i_cfg.fill_color;
            end
        end
    end

endmodule

### sv/rect_fill_border_copy_blitter_top.sv
`timescale 1ns / 1ps
// Top level of the rectangle fill/border/copy blitter: config registers,
// stream ports and output register. Depends on rfbc_pkg and rfbc_walker.
//
//  channel   | direction | signals                         | payload
//  ----------+-----------+---------------------------------+---------------------------
//  s_axis    | in        | tvalid, tready, tdata[7:0]      | step
//  m_axis    | out       | tvalid, tready, tdata, tlast    | pixel op, last
//  cfg       | in        | valid, ready, index[3:0], data  | register write
//
// One item per clock while the output side does not stall: the step is worked out from the walk
// counters in the accepting cycle and its pixel op appears in the output register in the cycle after.
// A full output register stalls input only while m_axis_tready is low.
// Reset (synchronous, active low) clears config registers, counters and output valid.
// A config write to a known index restarts the walk; the config port is always ready.
module rect_fill_border_copy_blitter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rfbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rfbc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rfbc_pkg::S_DATA_W-1:0]       s_axis_tdata,  // [0] step, rest zero
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] active, [17:1] write_x, [34:18] write_y, [35] write_en, [36] is_copy,
    // [53:37] read_x, [70:54] read_y, [71] read_en, [103:72] pixel_color
    output logic [rfbc_pkg::M_DATA_W-1:0]       m_axis_tdata,
    output logic                                m_axis_tlast
);
    import rfbc_pkg::*;

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_pix_op r_out_op;
    t_pix_op op;
    logic    s_accept;
    logic    cfg_write;
    logic    cfg_known;

    assign o_cfg_ready   = 1'b1;
    assign cfg_write     = i_cfg_valid;
    assign cfg_known     = (i_cfg_index <= CFG_DEST_Y);
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_MODE:       r_cfg.mode       <= t_mode'(i_cfg_data[1:0]);
                CFG_RECT_X:     r_cfg.rect_x     <= i_cfg_data[COORD_W-1:0];
                CFG_RECT_Y:     r_cfg.rect_y     <= i_cfg_data[COORD_W-1:0];
                CFG_RECT_W:     r_cfg.rect_w     <= i_cfg_data[COORD_W-1:0];
                CFG_RECT_H:     r_cfg.rect_h     <= i_cfg_data[COORD_W-1:0];
                CFG_FILL_COLOR: r_cfg.fill_color <= i_cfg_data[COLOR_W-1:0];
                CFG_DEST_X:     r_cfg.dest_x     <= i_cfg_data[COORD_W-1:0];
                CFG_DEST_Y:     r_cfg.dest_y     <= i_cfg_data[COORD_W-1:0];
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    rfbc_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (cfg_write && cfg_known),
        .i_accept  (s_accept),
        .i_step    (s_axis_tdata[0]),
        .o_op      (op)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_op <= op;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_op.last;
    assign m_axis_tdata  = {r_out_op.pixel_color, r_out_op.read_en, r_out_op.read_y,
                            r_out_op.read_x, r_out_op.is_copy, r_out_op.write_en,
                            r_out_op.write_y, r_out_op.write_x, r_out_op.active};

`ifndef SYNTHESIS
    a_accept_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    a_restart_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !s_axis_tdata[0]) |=> (!m_axis_tdata[0] && !m_axis_tlast))
        else $error("restart step issued a pixel op");

    a_flags_need_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tlast || m_axis_tdata[35] || m_axis_tdata[36]))
        |-> m_axis_tdata[0])
        else $error("last, write_en or is_copy set on an idle item");

    a_read_only_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[71]) |-> m_axis_tdata[36])
        else $error("read_en set outside copy mode");
`endif

endmodule

### verif/rect_fill_border_copy_blitter_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for rect_fill_border_copy_blitter_top: steps on s_axis, register
// writes on the cfg channel, pixel ops on m_axis checked against a walk predictor.
// Depends on rfbc_pkg and the top level.
module rect_fill_border_copy_blitter_top_test;
    import rfbc_pkg::*;

    localparam int unsigned ITEM_TARGET = 1350;
    localparam int unsigned QUIET_FROM  = 1200;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd15;
    localparam t_pix_op IDLE_OP = '0;

    typedef enum bit {ROW_REG, ROW_STEP} t_row_kind;
    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    stp;
        bit                    typed;
        t_pix_op               want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;   // [0] step
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] active, [17:1] write_x, [34:18] write_y, [35] write_en, [36] is_copy,
    // [53:37] read_x, [70:54] read_y, [71] read_en, [103:72] pixel_color
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;

    rect_fill_border_copy_blitter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    t_cfg            blit_regs = '0;
    logic [15:0]     outer_cnt = '0;
    logic [15:0]     inner_cnt = '0;
    bit              right_pend = 1'b0;
    bit              walk_fin = 1'b0;

    t_pix_op         expected_ops[$];
    t_dir_row        directed_rows[$];
    int unsigned     mismatches = 0;
    int unsigned     steps_sent = 0;
    int unsigned     cycle_cnt = 0;
    int unsigned     tready_hold = 0;
    bit              quiet_tail = 1'b0;

    function automatic void restart_walk();
        outer_cnt  = '0;
        inner_cnt  = '0;
        right_pend = 1'b0;
        walk_fin   = 1'b0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_MODE:       blit_regs.mode       = t_mode'(d[1:0]);
            CFG_RECT_X:     blit_regs.rect_x     = d[15:0];
            CFG_RECT_Y:     blit_regs.rect_y     = d[15:0];
            CFG_RECT_W:     blit_regs.rect_w     = d[15:0];
            CFG_RECT_H:     blit_regs.rect_h     = d[15:0];
            CFG_FILL_COLOR: blit_regs.fill_color = d;
            CFG_DEST_X:     blit_regs.dest_x     = d[15:0];
            CFG_DEST_Y:     blit_regs.dest_y     = d[15:0];
            default:        return;
        endcase
        restart_walk();
    endfunction

    function automatic bit on_screen(int unsigned x, int unsigned y);
        return x < SCREEN_WIDTH && y < SCREEN_HEIGHT;
    endfunction

    // next pixel op of the walk; advances the predictor state
    function automatic t_pix_op blit_next(bit stp);
        t_pix_op     op;
        int unsigned xo, yo, wx, wy, rx, ry, w, h;
        bit          next_row, fin;
        op = '0;
        xo = 0;
        yo = 0;
        next_row = 1'b0;
        fin = 1'b0;
        w = 32'(blit_regs.rect_w);
        h = 32'(blit_regs.rect_h);
        if (!stp) begin
            restart_walk();
            return op;
        end
        if (walk_fin)
            return op;
        if (blit_regs.mode == MODE_NONE || w == 0 || h == 0) begin
            walk_fin = 1'b1;
            return op;
        end
        if (blit_regs.mode == MODE_BORDER) begin
            // row-major: outer is the row, inner the column
            if (32'(outer_cnt) >= h || 32'(inner_cnt) >= w) begin
                walk_fin = 1'b1;
                return op;
            end
            yo = 32'(outer_cnt);
            if (yo == 0 || yo == h - 1) begin
                xo = 32'(inner_cnt);
                if (32'(inner_cnt) + 1 < w)
                    inner_cnt = inner_cnt + 16'd1;
                else
                    next_row = 1'b1;
                fin = (yo == h - 1) && (xo == w - 1);
            end else if (!right_pend) begin
                xo = 0;
                if (w > 1)
                    right_pend = 1'b1;
                else
                    next_row = 1'b1;
            end else begin
                xo = w - 1;
                right_pend = 1'b0;
                next_row = 1'b1;
            end
            if (next_row) begin
                inner_cnt = '0;
                outer_cnt = outer_cnt + 16'd1;
            end
        end else begin
            // column-major: outer is the column, inner the row
            if (32'(outer_cnt) >= w || 32'(inner_cnt) >= h) begin
                walk_fin = 1'b1;
                return op;
            end
            xo = 32'(outer_cnt);
            yo = 32'(inner_cnt);
            fin = (xo == w - 1) && (yo == h - 1);
            if (32'(inner_cnt) + 1 < h) begin
                inner_cnt = inner_cnt + 16'd1;
            end else begin
                inner_cnt = '0;
                outer_cnt = outer_cnt + 16'd1;
            end
        end
        if (fin)
            walk_fin = 1'b1;
        if (blit_regs.mode == MODE_COPY) begin
            rx = 32'(blit_regs.rect_x) + xo;
            ry = 32'(blit_regs.rect_y) + yo;
            wx = 32'(blit_regs.dest_x) + xo;
            wy = 32'(blit_regs.dest_y) + yo;
            op.is_copy = 1'b1;
            op.read_x  = rx[ADDR_W-1:0];
            op.read_y  = ry[ADDR_W-1:0];
            op.read_en = on_screen(rx, ry);
        end else begin
            wx = 32'(blit_regs.rect_x) + xo;
            wy = 32'(blit_regs.rect_y) + yo;
            op.pixel_color = blit_regs.fill_color;
        end
        op.active   = 1'b1;
        op.write_x  = wx[ADDR_W-1:0];
        op.write_y  = wy[ADDR_W-1:0];
        op.write_en = on_screen(wx, wy);
        op.last     = fin;
        return op;
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        directed_rows.push_back('{ROW_REG, idx, d, 1'b0, 1'b0, IDLE_OP});
    endfunction

    function automatic void add_step(bit stp);
        directed_rows.push_back('{ROW_STEP, '0, '0, stp, 1'b0, IDLE_OP});
    endfunction

    function automatic void add_checked(bit stp, t_pix_op want);
        directed_rows.push_back('{ROW_STEP, '0, '0, stp, 1'b1, want});
    endfunction

    function automatic logic [15:0] pick_pos(int unsigned lim);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'($urandom_range(0, 20));
            2:       return 16'(lim - 4 + $urandom_range(0, 8));
            3:       return 16'hFFFF - 16'($urandom_range(0, 20));
            4:       return 16'($urandom);
            default: return 16'($urandom_range(0, lim));
        endcase
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return 16'hFFFF;
            1:       return 16'($urandom);
            2, 3:    return 16'($urandom_range(7, 16));
            default: return 16'($urandom_range(0, 6));
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_step(bit stp, bit typed, t_pix_op want);
        t_pix_op op;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W-1){1'b0}}, stp};
        do @(posedge i_clk); while (!s_axis_tready);
        op = blit_next(stp);
        expected_ops.push_back(typed ? want : op);
        steps_sent++;
    endtask

    task automatic maybe_gap();
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding pixel op come back
    task automatic wait_results_out();
        s_axis_tvalid <= 1'b0;
        while (expected_ops.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic check_field(string nm, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", nm, want, got);
            mismatches++;
        end
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        if (tready_hold != 0) begin
            tready_hold <= tready_hold - 1;
        end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
            m_axis_tready <= 1'b1;
            tready_hold   <= $urandom_range(0, 30);
        end else begin
            m_axis_tready <= 1'b0;
            tready_hold   <= $urandom_range(0, 18);
        end
    end

    always @(posedge i_clk) begin
        t_pix_op want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_ops.size() == 0) begin
                $error("pixel op item with nothing expected");
                mismatches++;
            end else begin
                want = expected_ops.pop_front();
                check_field("active",      32'(want.active),   32'(m_axis_tdata[0]));
                check_field("write_x",     32'(want.write_x),  32'(m_axis_tdata[17:1]));
                check_field("write_y",     32'(want.write_y),  32'(m_axis_tdata[34:18]));
                check_field("write_en",    32'(want.write_en), 32'(m_axis_tdata[35]));
                check_field("is_copy",     32'(want.is_copy),  32'(m_axis_tdata[36]));
                check_field("read_x",      32'(want.read_x),   32'(m_axis_tdata[53:37]));
                check_field("read_y",      32'(want.read_y),   32'(m_axis_tdata[70:54]));
                check_field("read_en",     32'(want.read_en),  32'(m_axis_tdata[71]));
                check_field("pixel_color", want.pixel_color,   m_axis_tdata[103:72]);
                check_field("last",        32'(want.last),     32'(m_axis_tlast));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] d;
        int unsigned           area, n, phase_no;
        bit                    all_regs, paused;
        phase_no = 0;
        paused = 1'b0;

        // after reset: empty rectangle, then a restart
        add_checked(1'b1, IDLE_OP);
        add_checked(1'b0, IDLE_OP);
        // 2x2 fill on the bottom-right screen corner, restarted mid-walk
        add_reg(CFG_RECT_X, 32'd1023);
        add_reg(CFG_RECT_Y, 32'd767);
        add_reg(CFG_RECT_W, 32'd2);
        add_reg(CFG_RECT_H, 32'd2);
        add_reg(CFG_FILL_COLOR, 32'hFFFF_FFFF);
        add_checked(1'b1, t_pix_op'{1'b1, 17'd1023, 17'd767, 1'b1, 1'b0, 17'd0, 17'd0,
                                    1'b0, 32'hFFFF_FFFF, 1'b0});
        add_step(1'b1);
        add_checked(1'b0, IDLE_OP);
        add_checked(1'b1, t_pix_op'{1'b1, 17'd1023, 17'd767, 1'b1, 1'b0, 17'd0, 17'd0,
                                    1'b0, 32'hFFFF_FFFF, 1'b0});
        add_step(1'b1);
        add_step(1'b1);
        add_checked(1'b1, t_pix_op'{1'b1, 17'd1024, 17'd768, 1'b0, 1'b0, 17'd0, 17'd0,
                                    1'b0, 32'hFFFF_FFFF, 1'b1});
        add_checked(1'b1, IDLE_OP);
        // narrow border, then a one-row border
        add_reg(CFG_MODE, 32'(MODE_BORDER));
        add_reg(CFG_RECT_X, 32'd0);
        add_reg(CFG_RECT_Y, 32'd0);
        add_reg(CFG_RECT_W, 32'd1);
        add_reg(CFG_RECT_H, 32'd3);
        add_reg(CFG_FILL_COLOR, 32'd0);
        repeat (4) add_step(1'b1);
        add_reg(CFG_RECT_W, 32'd2);
        add_reg(CFG_RECT_H, 32'd1);
        repeat (2) add_step(1'b1);
        // copy with the source at the far coordinate limit and the destination at the far x limit
        add_reg(CFG_MODE, 32'(MODE_COPY));
        add_reg(CFG_RECT_X, 32'hFFFF);
        add_reg(CFG_RECT_Y, 32'hFFFF);
        add_reg(CFG_RECT_W, 32'd1);
        add_reg(CFG_RECT_H, 32'd1);
        add_reg(CFG_DEST_X, 32'hFFFF);
        add_reg(CFG_DEST_Y, 32'd0);
        add_checked(1'b1, t_pix_op'{1'b1, 17'd65535, 17'd0, 1'b0, 1'b1, 17'd65535, 17'd65535,
                                    1'b0, 32'd0, 1'b1});
        add_reg(CFG_RECT_X, 32'd0);
        add_reg(CFG_RECT_Y, 32'd0);
        add_reg(CFG_DEST_X, 32'd5);
        add_reg(CFG_DEST_Y, 32'd767);
        add_step(1'b1);
        // invalid mode does nothing
        add_reg(CFG_MODE, 32'(MODE_NONE));
        add_checked(1'b1, IDLE_OP);
        // a write past the register list must not restart a finished walk
        add_reg(CFG_MODE, 32'(MODE_FILL));
        add_step(1'b1);
        add_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);
        add_checked(1'b1, IDLE_OP);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_REG) begin
                wait_results_out();
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                maybe_gap();
                send_step(directed_rows[r].stp, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // random walks, each set up while the block is idle
        while (steps_sent < ITEM_TARGET) begin
            wait_results_out();
            all_regs = (phase_no == 0);
            if (all_regs || $urandom_range(0, 1)) begin
                d = $urandom;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: d[1:0] = MODE_FILL;
                    4, 5, 6:    d[1:0] = MODE_BORDER;
                    7, 8:       d[1:0] = MODE_COPY;
                    default:    d[1:0] = MODE_NONE;
                endcase
                write_reg(CFG_MODE, d);
            end
            if (all_regs || $urandom_range(0, 1)) begin
                d = $urandom;
                d[15:0] = pick_pos(SCREEN_WIDTH);
                write_reg(CFG_RECT_X, d);
            end
            if (all_regs || $urandom_range(0, 1)) begin
                d = $urandom;
                d[15:0] = pick_pos(SCREEN_HEIGHT);
                write_reg(CFG_RECT_Y, d);
            end
            if (all_regs || $urandom_range(0, 1)) begin
                d = $urandom;
                d[15:0] = pick_size();
                write_reg(CFG_RECT_W, d);
            end
            if (all_regs || $urandom_range(0, 1)) begin
                d = $urandom;
                d[15:0] = pick_size();
                write_reg(CFG_RECT_H, d);
            end
            if (all_regs || $urandom_range(0, 1))
                write_reg(CFG_FILL_COLOR, $urandom);
            if (all_regs || $urandom_range(0, 1)) begin
                d = $urandom;
                d[15:0] = pick_pos(SCREEN_WIDTH);
                write_reg(CFG_DEST_X, d);
            end
            if (all_regs || $urandom_range(0, 1)) begin
                d = $urandom;
                d[15:0] = pick_pos(SCREEN_HEIGHT);
                write_reg(CFG_DEST_Y, d);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(8, 15)), $urandom);

            area = 32'(blit_regs.rect_w) * 32'(blit_regs.rect_h);
            n = (area > 48 ? 48 : area) + $urandom_range(0, 3);
            for (int k = 0; k < n; k++) begin
                if (steps_sent >= QUIET_FROM)
                    quiet_tail = 1'b1;
                // one mid-walk pause until the output side has caught up
                if (phase_no >= 5 && !paused && k > 0) begin
                    wait_results_out();
                    paused = 1'b1;
                end
                maybe_gap();
                send_step($urandom_range(0, 24) != 0, 1'b0, IDLE_OP);
            end
            phase_no++;
        end

        s_axis_tvalid <= 1'b0;
        while (expected_ops.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
